[hw/rtl/spps_pkg.sv]
// ----------------------------------------------------------------------------
// spps_pkg
// Shared widths, control word layout and microcode for the stepper position
// PID step block.
// ----------------------------------------------------------------------------
package spps_pkg;

    localparam int AngleW = 32;
    localparam int CurW   = 31;
    localparam int GainW  = 32;
    localparam int FiltW  = 16;
    localparam int CfgIdxW = 3;
    localparam int OperW  = 33;
    localparam int ProdW  = 2 * OperW;
    localparam int TdataW = 64;

    localparam int NumSteps = 10;
    localparam int StepW    = $clog2(NumSteps);

    typedef logic [StepW-1:0] step_t;

    // register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        REG_CLOSED_LOOP,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_EFFORT_LIMIT,
        REG_FILTER_KEEP,
        REG_FILTER_GAIN,
        REG_HOLD_CURRENT
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_ERR,
        OP_DIFF,
        OP_PTERM,
        OP_ITERM,
        OP_KDD,
        OP_KEEP,
        OP_FEED,
        OP_SUM,
        OP_OUT,
        OP_OPEN
    } op_t;

    typedef enum logic [2:0] {
        MA_GP,
        MA_GI,
        MA_GD,
        MA_FK,
        MA_FG
    } mula_t;

    typedef enum logic [1:0] {
        MB_ERR,
        MB_DIFF,
        MB_DF,
        MB_KDD
    } mulb_t;

    typedef struct packed {
        op_t   op;
        logic  mul_en;
        mula_t mula;
        mulb_t mulb;
        logic  jmp_open;
        step_t jmp_to;
        logic  done;
    } ctrl_t;

    localparam step_t STEP_FIRST = step_t'(0);
    localparam step_t STEP_OPEN  = step_t'(9);

    // control store: one word per step
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t c;
        c = '{op: OP_OPEN, mul_en: 1'b0, mula: MA_GP, mulb: MB_ERR,
              jmp_open: 1'b0, jmp_to: STEP_FIRST, done: 1'b1};
        case (pc)
            step_t'(0):
            begin
                c.op       = OP_ERR;
                c.jmp_open = 1'b1;
                c.jmp_to   = STEP_OPEN;
                c.done     = 1'b0;
            end
            step_t'(1):
            begin
                c.op = OP_DIFF;  c.mul_en = 1'b1; c.mula = MA_GP; c.mulb = MB_ERR;
                c.done = 1'b0;
            end
            step_t'(2):
            begin
                c.op = OP_PTERM; c.mul_en = 1'b1; c.mula = MA_GI; c.mulb = MB_ERR;
                c.done = 1'b0;
            end
            step_t'(3):
            begin
                c.op = OP_ITERM; c.mul_en = 1'b1; c.mula = MA_GD; c.mulb = MB_DIFF;
                c.done = 1'b0;
            end
            step_t'(4):
            begin
                c.op = OP_KDD;   c.mul_en = 1'b1; c.mula = MA_FK; c.mulb = MB_DF;
                c.done = 1'b0;
            end
            step_t'(5):
            begin
                c.op = OP_KEEP;  c.mul_en = 1'b1; c.mula = MA_FG; c.mulb = MB_KDD;
                c.done = 1'b0;
            end
            step_t'(6):
            begin
                c.op = OP_FEED;  c.done = 1'b0;
            end
            step_t'(7):
            begin
                c.op = OP_SUM;   c.done = 1'b0;
            end
            step_t'(8):
            begin
                c.op = OP_OUT;
            end
            default:
            begin
                c.op = OP_OPEN;
            end
        endcase
        return c;
    endfunction

    // saturate a wide signed value to 32 bits
    function automatic logic signed [AngleW-1:0] sat32(input logic signed [ProdW-1:0] x);
        logic signed [AngleW-1:0] r;
        if ((&x[ProdW-1:AngleW-1]) || !(|x[ProdW-1:AngleW-1]))
        begin
            r = x[AngleW-1:0];
        end
        else if (x[ProdW-1])
        begin
            r = {1'b1, {(AngleW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(AngleW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[hw/rtl/stepper_position_pid_step.sv]
// ----------------------------------------------------------------------------
// stepper_position_pid_step
// Position loop for a stepper run as a servo: PID with clamped integral and
// low-pass filtered derivative, driven by a small microcoded sequencer around
// one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   target_angle, measured_angle
//  m_*       out        m_tvalid / m_tready   drive_angle, drive_current
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  closed loop: the sequencer walks nine control steps per item, five of them
//  feeding the one multiplier
//  open loop: error step, then jump to the open step
//  a result waits in the output register while the next item is worked on;
//  the sequencer holds on its final step only if that register is still full
//  reset clears config to defaults and the integral, filter and error history
// ----------------------------------------------------------------------------
module stepper_position_pid_step
(
    input  logic                              clk,
    input  logic                              rst_n,
    // target_angle [31:0], measured_angle [63:32]
    input  logic [spps_pkg::TdataW-1:0]       s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // drive_angle [31:0], drive_current [62:32], zero [63]
    output logic [spps_pkg::TdataW-1:0]       m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spps_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int AW = spps_pkg::AngleW;
    localparam int CW = spps_pkg::CurW;
    localparam int PW = spps_pkg::ProdW;
    localparam int OW = spps_pkg::OperW;
    localparam int FW = spps_pkg::FiltW;

    // configuration
    logic                 closed_loop_reg;
    logic signed [31:0]   gain_p_reg, gain_i_reg, gain_d_reg;
    logic [CW-1:0]        effort_limit_reg, hold_current_reg;
    logic [FW-1:0]        filter_keep_reg, filter_gain_reg;

    // loop state
    logic signed [AW-1:0] integ_reg, integ_next;
    logic signed [AW-1:0] dfilt_reg, dfilt_next;
    logic signed [AW-1:0] prev_err_reg, prev_err_next;

    // sequencer
    logic                 busy_reg;
    spps_pkg::step_t      pc_reg;
    spps_pkg::ctrl_t      ctrl;
    logic                 out_free;
    logic                 in_xfer;

    // datapath scratch
    logic signed [AW-1:0] tgt_reg, meas_reg;
    logic signed [AW-1:0] err_reg, err_next;
    logic signed [OW-1:0] diff_reg, diff_next;
    logic signed [AW-1:0] p_reg, p_next;
    logic signed [AW-1:0] kdd_reg, kdd_next;
    logic signed [33:0]   keep_reg, keep_next;
    logic signed [33:0]   sum_reg, sum_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [OW-1:0] mul_a, mul_b;

    // output register
    logic                 m_valid_reg;
    logic signed [AW-1:0] angle_reg, angle_next;
    logic [CW-1:0]        cur_reg, cur_next;

    // intermediate values
    logic signed [OW-1:0] err_wide;
    logic signed [51:0]   isum;
    logic signed [51:0]   lim_i;
    logic signed [34:0]   dsum;
    logic signed [OW-1:0] ang_wide;
    logic signed [33:0]   mag;
    logic signed [33:0]   lim_m;

    assign ctrl      = spps_pkg::ucode(pc_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, cur_reg, angle_reg};

    // shared multiplier operands
    always_comb
    begin
        case (ctrl.mula)
            spps_pkg::MA_GP: mul_a = OW'(gain_p_reg);
            spps_pkg::MA_GI: mul_a = OW'(gain_i_reg);
            spps_pkg::MA_GD: mul_a = OW'(gain_d_reg);
            spps_pkg::MA_FK: mul_a = $signed({{(OW-FW){1'b0}}, filter_keep_reg});
            spps_pkg::MA_FG: mul_a = $signed({{(OW-FW){1'b0}}, filter_gain_reg});
            default:         mul_a = '0;
        endcase
        case (ctrl.mulb)
            spps_pkg::MB_ERR:  mul_b = OW'(err_reg);
            spps_pkg::MB_DIFF: mul_b = diff_reg;
            spps_pkg::MB_DF:   mul_b = OW'(dfilt_reg);
            spps_pkg::MB_KDD:  mul_b = OW'(kdd_reg);
            default:           mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // one datapath operation per step
    always_comb
    begin
        err_next      = err_reg;
        diff_next     = diff_reg;
        p_next        = p_reg;
        kdd_next      = kdd_reg;
        keep_next     = keep_reg;
        sum_next      = sum_reg;
        integ_next    = integ_reg;
        dfilt_next    = dfilt_reg;
        prev_err_next = prev_err_reg;
        angle_next    = angle_reg;
        cur_next      = cur_reg;

        err_wide = OW'(tgt_reg) - OW'(meas_reg);
        lim_i    = $signed({{(52-CW){1'b0}}, effort_limit_reg});
        isum     = 52'(integ_reg) + 52'($signed(prod_reg[PW-1:16]));
        dsum     = 35'(keep_reg) - 35'($signed(prod_reg[48:15]));
        lim_m    = $signed({{(34-CW){1'b0}}, effort_limit_reg});
        if (sum_reg > 34'sd0)
        begin
            ang_wide = OW'(meas_reg) + 33'sd256;
            mag      = sum_reg;
        end
        else
        begin
            ang_wide = OW'(meas_reg) - 33'sd256;
            mag      = -sum_reg;
        end

        case (ctrl.op)
            spps_pkg::OP_ERR:
            begin
                err_next = spps_pkg::sat32(PW'(err_wide));
            end
            spps_pkg::OP_DIFF:
            begin
                diff_next = OW'(err_reg) - OW'(prev_err_reg);
            end
            spps_pkg::OP_PTERM:
            begin
                p_next = spps_pkg::sat32(prod_reg >>> 16);
            end
            spps_pkg::OP_ITERM:
            begin
                if (isum > lim_i)
                begin
                    integ_next = AW'(lim_i);
                end
                else if (isum < -lim_i)
                begin
                    integ_next = AW'(-lim_i);
                end
                else
                begin
                    integ_next = AW'(isum);
                end
            end
            spps_pkg::OP_KDD:
            begin
                kdd_next = spps_pkg::sat32(prod_reg >>> 16);
            end
            spps_pkg::OP_KEEP:
            begin
                keep_next = $signed(prod_reg[48:15]);
            end
            spps_pkg::OP_FEED:
            begin
                dfilt_next    = spps_pkg::sat32(PW'(dsum));
                prev_err_next = err_reg;
            end
            spps_pkg::OP_SUM:
            begin
                sum_next = 34'(p_reg) + 34'(integ_reg) + 34'(dfilt_reg);
            end
            spps_pkg::OP_OUT:
            begin
                angle_next = spps_pkg::sat32(PW'(ang_wide));
                cur_next   = (mag > lim_m) ? effort_limit_reg : CW'(mag);
            end
            spps_pkg::OP_OPEN:
            begin
                angle_next = tgt_reg;
                cur_next   = hold_current_reg;
            end
            default:
            begin
                err_next = err_reg;
            end
        endcase
    end

    // sequencer, configuration and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pc_reg           <= spps_pkg::STEP_FIRST;
            m_valid_reg      <= 1'b0;
            closed_loop_reg  <= 1'b1;
            gain_p_reg       <= 32'sd1677722;
            gain_i_reg       <= 32'sd1678;
            gain_d_reg       <= 32'sd0;
            effort_limit_reg <= CW'(65536);
            filter_keep_reg  <= FW'(29491);
            filter_gain_reg  <= FW'(3277);
            hold_current_reg <= CW'(26214);
            integ_reg        <= '0;
            dfilt_reg        <= '0;
            prev_err_reg     <= '0;
        end
        else
        begin
            // a new result may replace one that transfers in the same cycle
            if (busy_reg && ctrl.done && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (in_xfer)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= spps_pkg::STEP_FIRST;
            end
            else if (busy_reg)
            begin
                if (ctrl.done)
                begin
                    if (out_free)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                else if (ctrl.jmp_open && !closed_loop_reg)
                begin
                    pc_reg <= ctrl.jmp_to;
                end
                else
                begin
                    pc_reg <= pc_reg + spps_pkg::step_t'(1);
                end
            end

            if (busy_reg && !ctrl.done)
            begin
                integ_reg    <= integ_next;
                dfilt_reg    <= dfilt_next;
                prev_err_reg <= prev_err_next;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (spps_pkg::cfg_reg_t'(cfg_index))
                    spps_pkg::REG_CLOSED_LOOP:  closed_loop_reg  <= cfg_data[0];
                    spps_pkg::REG_GAIN_P:       gain_p_reg       <= $signed(cfg_data);
                    spps_pkg::REG_GAIN_I:       gain_i_reg       <= $signed(cfg_data);
                    spps_pkg::REG_GAIN_D:       gain_d_reg       <= $signed(cfg_data);
                    spps_pkg::REG_EFFORT_LIMIT: effort_limit_reg <= cfg_data[CW-1:0];
                    spps_pkg::REG_FILTER_KEEP:  filter_keep_reg  <= cfg_data[FW-1:0];
                    spps_pkg::REG_FILTER_GAIN:  filter_gain_reg  <= cfg_data[FW-1:0];
                    spps_pkg::REG_HOLD_CURRENT: hold_current_reg <= cfg_data[CW-1:0];
                    default:                    closed_loop_reg  <= closed_loop_reg;
                endcase
            end
        end
    end

    // payload, scratch and output registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tgt_reg  <= $signed(s_tdata[AW-1:0]);
            meas_reg <= $signed(s_tdata[2*AW-1:AW]);
        end
        if (busy_reg && !ctrl.done)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
            p_reg    <= p_next;
            kdd_reg  <= kdd_next;
            keep_reg <= keep_next;
            sum_reg  <= sum_next;
        end
        if (busy_reg && ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        // result lands only when the output register is free
        if (busy_reg && ctrl.done && out_free)
        begin
            angle_reg <= angle_next;
            cur_reg   <= cur_next;
        end
    end

endmodule

[hw/rtl/spps_checker.sv]
// ----------------------------------------------------------------------------
// spps_checker
// Port-level checks for the stepper position PID step block, bound to the
// top level.
// ----------------------------------------------------------------------------
module spps_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [spps_pkg::TdataW-1:0] m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time: input closes after a transfer
    a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after transfer");

    // a result needs at least two sequencer steps after its input
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after input transfer");

    // padding bit above drive_current stays clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[spps_pkg::TdataW-1])
        else $error("output padding bit set");

endmodule

bind stepper_position_pid_step spps_checker u_spps_checker (.*);
